>>> src/rtmp_chunk_segmenter_macros.svh
`ifndef RTMP_CHUNK_SEGMENTER_MACROS_SVH
`define RTMP_CHUNK_SEGMENTER_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define RCS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/rcs_pkg.sv
`timescale 1ns / 1ps
package rcs_pkg;

   localparam int unsigned CSID_W      = 17;
   localparam int unsigned LEN_W       = 24;
   localparam int unsigned IDX_W       = 5;
   localparam int unsigned REQ_DATA_W  = 128;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [23:0] TS_SAT           = 24'hFFFFFF;
   localparam logic [23:0] CHUNK_SIZE_RESET = 24'd128;

   // basic header id ranges
   localparam logic [16:0] CSID_TWO_BYTE_MIN   = 17'd64;
   localparam logic [16:0] CSID_THREE_BYTE_MIN = 17'd320;
   localparam logic [16:0] CSID_BIAS           = 17'd64;

   localparam logic [1:0] FMT_TYPE0 = 2'd0;
   localparam logic [1:0] FMT_TYPE3 = 2'd3;

   localparam logic [IDX_W-1:0] TYPE0_FIXED_LEN = 5'd11;
   localparam logic [IDX_W-1:0] EXT_TS_LEN      = 5'd4;

   typedef enum logic [0:0] {
      CSR_CHUNK_SIZE = 1'b0
   } csr_index_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_header;
      logic       end_of_message;
      logic       last_of_run;
   } beat_type;

endpackage

>>> src/rcs_csr.sv
`timescale 1ns / 1ps
module rcs_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rcs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rcs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rcs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output logic [rcs_pkg::LEN_W-1:0]       chunk_size
);
   import rcs_pkg::*;

   logic [LEN_W-1:0] chunk_size_ff, chunk_size_in;
   csr_index_type    index;
   logic             write_en;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      chunk_size_in = chunk_size_ff;
      csr_prdata    = '0;
      unique case (index)
         CSR_CHUNK_SIZE: begin
            csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, chunk_size_ff};
            if (write_en) begin
               chunk_size_in = csr_pwdata[LEN_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= CHUNK_SIZE_RESET;
      end else begin
         chunk_size_ff <= chunk_size_in;
      end
   end

   assign chunk_size = chunk_size_ff;

endmodule

>>> src/rcs_framer.sv
`timescale 1ns / 1ps
module rcs_framer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rcs_pkg::LEN_W-1:0]   chunk_size,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [7:0]                  data_byte,
   input  logic                        start_of_message,
   input  logic [rcs_pkg::CSID_W-1:0]  chunk_stream_id,
   input  logic [31:0]                 timestamp,
   input  logic [31:0]                 message_stream_id,
   input  logic [7:0]                  message_type,
   input  logic [rcs_pkg::LEN_W-1:0]   message_length,
   output logic                        beat_valid,
   output rcs_pkg::beat_type           beat,
   input  logic                        beat_ready
);
   import rcs_pkg::*;

   typedef struct packed {
      logic [7:0]       data;
      logic             eom;
      logic [2:0][7:0]  basic;
      logic [1:0]       basic_len;
      logic [IDX_W-1:0] hdr_len;
      logic [31:0]      ts;
      logic [31:0]      msid;
      logic [7:0]       mtype;
      logic [LEN_W-1:0] mlen;
   } item_type;

   logic [CSID_W-1:0] active_id_ff, active_id_in;
   logic [LEN_W-1:0]  msg_left_ff, msg_left_in;
   logic [LEN_W-1:0]  chunk_left_ff, chunk_left_in;
   logic              item_valid_ff, item_valid_in;
   item_type          item_ff, item_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic              accept, drop, load, emit, finish;
   logic [CSID_W-1:0] id;
   logic [CSID_W-1:0] biased;
   logic [1:0]        fmt;
   logic [2:0][7:0]   basic;
   logic [1:0]        basic_len;
   logic              ext_ts;
   logic [LEN_W-1:0]  reload;
   logic [IDX_W-1:0]  tail_idx;
   logic [23:0]       t24;

   // basic header for either a new message or a chunk continuation
   assign id     = start_of_message ? chunk_stream_id : active_id_ff;
   assign fmt    = start_of_message ? FMT_TYPE0 : FMT_TYPE3;
   assign biased = id - CSID_BIAS;

   always_comb begin
      basic = '0;
      if (id >= CSID_THREE_BYTE_MIN) begin
         basic[0]  = {fmt, 6'd1};
         basic[1]  = biased[7:0];
         basic[2]  = biased[15:8];
         basic_len = 2'd3;
      end else if (id >= CSID_TWO_BYTE_MIN) begin
         basic[0]  = {fmt, 6'd0};
         basic[1]  = biased[7:0];
         basic_len = 2'd2;
      end else begin
         basic[0]  = {fmt, id[5:0]};
         basic_len = 2'd1;
      end
   end

   assign ext_ts = (timestamp[31:24] != 8'd0) || (timestamp[23:0] == TS_SAT);
   // chunk size zero acts as one
   assign reload = (chunk_size == '0) ? '0 : chunk_size - 1'b1;

   always_comb begin
      drop           = 1'b1;
      active_id_in   = active_id_ff;
      msg_left_in    = msg_left_ff;
      chunk_left_in  = chunk_left_ff;
      item_in        = '0;
      item_in.data   = data_byte;
      item_in.basic  = basic;
      item_in.basic_len = basic_len;
      item_in.ts     = timestamp;
      item_in.msid   = message_stream_id;
      item_in.mtype  = message_type;
      item_in.mlen   = message_length;
      if (start_of_message) begin
         msg_left_in   = '0;
         chunk_left_in = '0;
         if (message_length != '0) begin
            drop            = 1'b0;
            active_id_in    = chunk_stream_id;
            item_in.hdr_len = {3'b000, basic_len} + TYPE0_FIXED_LEN
                              + (ext_ts ? EXT_TS_LEN : '0);
            msg_left_in     = message_length - 1'b1;
            chunk_left_in   = reload;
            item_in.eom     = (message_length == 24'd1);
         end
      end else if (msg_left_ff != '0) begin
         drop        = 1'b0;
         msg_left_in = msg_left_ff - 1'b1;
         item_in.eom = (msg_left_ff == 24'd1);
         if (chunk_left_ff == '0) begin
            item_in.hdr_len = {3'b000, basic_len};
            chunk_left_in   = reload;
         end else begin
            chunk_left_in = chunk_left_ff - 1'b1;
         end
      end
   end

   // one byte leaves per cycle the output stage can take
   assign emit     = item_valid_ff && beat_ready;
   assign finish   = emit && (idx_ff == item_ff.hdr_len);
   assign in_ready = !item_valid_ff || finish;
   assign accept   = in_valid && in_ready;
   assign load     = accept && !drop;

   always_comb begin
      item_valid_in = item_valid_ff;
      idx_in        = idx_ff;
      if (load) begin
         item_valid_in = 1'b1;
         idx_in        = '0;
      end else if (finish) begin
         item_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   assign tail_idx = idx_ff - {3'b000, item_ff.basic_len};
   assign t24      = (item_ff.ts[31:24] != 8'd0) ? TS_SAT : item_ff.ts[23:0];

   always_comb begin
      beat_valid          = emit;
      beat.is_header      = 1'b0;
      beat.end_of_message = 1'b0;
      beat.last_of_run    = 1'b0;
      beat.out_byte       = item_ff.data;
      if (idx_ff < item_ff.hdr_len) begin
         beat.is_header = 1'b1;
         if (idx_ff < {3'b000, item_ff.basic_len}) begin
            beat.out_byte = item_ff.basic[idx_ff[1:0]];
         end else begin
            case (tail_idx)
               5'd0:    beat.out_byte = t24[23:16];
               5'd1:    beat.out_byte = t24[15:8];
               5'd2:    beat.out_byte = t24[7:0];
               5'd3:    beat.out_byte = item_ff.mlen[23:16];
               5'd4:    beat.out_byte = item_ff.mlen[15:8];
               5'd5:    beat.out_byte = item_ff.mlen[7:0];
               5'd6:    beat.out_byte = item_ff.mtype;
               5'd7:    beat.out_byte = item_ff.msid[7:0];
               5'd8:    beat.out_byte = item_ff.msid[15:8];
               5'd9:    beat.out_byte = item_ff.msid[23:16];
               5'd10:   beat.out_byte = item_ff.msid[31:24];
               5'd11:   beat.out_byte = item_ff.ts[31:24];
               5'd12:   beat.out_byte = item_ff.ts[23:16];
               5'd13:   beat.out_byte = item_ff.ts[15:8];
               5'd14:   beat.out_byte = item_ff.ts[7:0];
               default: beat.out_byte = 8'd0;
            endcase
         end
      end else begin
         beat.end_of_message = item_ff.eom;
         beat.last_of_run    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_id_ff  <= '0;
         msg_left_ff   <= '0;
         chunk_left_ff <= '0;
         item_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         if (accept) begin
            active_id_ff  <= active_id_in;
            msg_left_ff   <= msg_left_in;
            chunk_left_ff <= chunk_left_in;
         end
         item_valid_ff <= item_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

endmodule

>>> src/rcs_out_stage.sv
`timescale 1ns / 1ps
module rcs_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rcs_pkg::beat_type beat,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);
   import rcs_pkg::*;

   logic     valid_ff, valid_in;
   beat_type beat_ff;

   assign in_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         beat_ff <= beat;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = beat_ff.out_byte;
   assign rsp_tuser  = {beat_ff.end_of_message, beat_ff.is_header};
   assign rsp_tlast  = beat_ff.last_of_run;

endmodule

>>> src/rtmp_chunk_segmenter.sv
`timescale 1ns / 1ps
// chunk stream packetizer: one message payload byte per req item, chunked bytes out on rsp
// req channel: first byte of a message has tuser set and carries the chunk stream id,
//   timestamp, message stream id, type and length in tdata; later bytes use only tdata[7:0]
// rsp channel: one output byte per item; tuser marks header bytes and the final payload
//   byte of the message, tlast marks the payload byte that closes each input's run
// a first byte yields a type-0 header of 12 to 18 bytes plus the payload byte; a byte at a
//   chunk boundary yields a 1 to 3 byte type-3 header plus the payload byte
// an accepted item sits in the item register; its bytes reach rsp via the output register
// throughput: one output byte per cycle while rsp is not stalled, so plain payload bytes
//   stream at one item per cycle; an item with a header holds the input while it is sent
// items outside a message, and starts with zero length, are taken and dropped at once
// a stall on rsp holds the output register; the header sequencer waits, and req backs up
//   once the held item is still being serialized
// reset clears the message state and both stages; chunk_size returns to 128
// csr: chunk_size at byte address 0, written on the access cycle, pready always high
module rtmp_chunk_segmenter (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata fields from bit 0: data_byte, chunk_stream_id, timestamp,
   // message_stream_id, message_type, message_length, zero fill
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rcs_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tuser,   // start_of_message
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // out_byte
   output logic [1:0]                          rsp_tuser,   // is_header, end_of_message
   output logic                                rsp_tlast,   // last_of_run
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rcs_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [rcs_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [rcs_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import rcs_pkg::*;

   logic [LEN_W-1:0] chunk_size;
   logic             beat_valid, beat_ready;
   beat_type         beat;

   // configuration register
   rcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .chunk_size  (chunk_size)
   );

   // message tracking, item register and header byte sequencing
   rcs_framer u_framer (
      .clock             (clock),
      .reset             (reset),
      .chunk_size        (chunk_size),
      .in_valid          (req_tvalid),
      .in_ready          (req_tready),
      .data_byte         (req_tdata[7:0]),
      .start_of_message  (req_tuser),
      .chunk_stream_id   (req_tdata[24:8]),
      .timestamp         (req_tdata[56:25]),
      .message_stream_id (req_tdata[88:57]),
      .message_type      (req_tdata[96:89]),
      .message_length    (req_tdata[120:97]),
      .beat_valid        (beat_valid),
      .beat              (beat),
      .beat_ready        (beat_ready)
   );

   // result register facing the rsp channel
   rcs_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (beat_valid),
      .in_ready   (beat_ready),
      .beat       (beat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> src/rcs_checker.sv
`timescale 1ns / 1ps
`include "rtmp_chunk_segmenter_macros.svh"
module rcs_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // a stalled result holds its byte and flags
   `RCS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "rsp item changed while stalled")

   // header bytes never close a run and never end a message
   `RCS_ASSERT_NOW(a_hdr_flags, rsp_tvalid && rsp_tuser[0], !rsp_tlast && !rsp_tuser[1], "header byte carries payload flags")

   // the end of a message is always the payload byte that closes its run
   `RCS_ASSERT_NOW(a_eom_last, rsp_tvalid && rsp_tuser[1], rsp_tlast, "end of message without end of run")

endmodule

bind rtmp_chunk_segmenter rcs_checker u_checker (.*);

>>> tb/sv/tb_rtmp_chunk_segmenter.sv
`timescale 1ns / 1ps
module tb_rtmp_chunk_segmenter;
   import rcs_pkg::*;

   // cycles with no handshake on any port before the run is called hung
   localparam int STUCK_LIMIT  = 2000;
   // idle cycles after the last expected byte, covers the two-stage pipeline
   localparam int SETTLE_CYCLES = 8;
   localparam int ITEM_TARGET   = 500;
   localparam logic [CSR_ADDR_W-1:0] CHUNK_SIZE_ADDR =
      CSR_ADDR_W'(4 * int'(CSR_CHUNK_SIZE));

   // one req item as the block sees it
   typedef struct {
      logic [7:0]  data;
      logic        som;
      logic [16:0] csid;
      logic [31:0] ts;
      logic [31:0] msid;
      logic [7:0]  mtype;
      logic [23:0] mlen;
   } msg_byte_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // fields from bit 0: data_byte, chunk_stream_id, timestamp, message_stream_id,
   // message_type, message_length, zero fill
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tuser;    // start_of_message
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [7:0]             rsp_tdata;    // out_byte
   logic [1:0]             rsp_tuser;    // is_header, end_of_message
   logic                   rsp_tlast;    // last_of_run
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // packetizer state as predicted by the testbench
   logic [23:0] cfg_chunk_size;
   logic [16:0] cur_csid;
   logic [23:0] msg_left;
   logic [23:0] chunk_left;

   // chunked bytes still owed by the block, oldest first
   beat_type chunk_bytes_due[$];

   int  errors;
   int  stuck_cycles;
   int  rsp_hold;
   // when set, neither side starts a new gap
   bit  quiet;

   rtmp_chunk_segmenter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   function automatic void push_header_byte(logic [7:0] b);
      beat_type beat;
      beat.out_byte       = b;
      beat.is_header      = 1'b1;
      beat.end_of_message = 1'b0;
      beat.last_of_run    = 1'b0;
      chunk_bytes_due.push_back(beat);
   endfunction

   // basic header: one, two or three bytes depending on the id range
   function automatic void push_basic_header(logic [1:0] fmt, logic [16:0] id);
      logic [16:0] biased;
      biased = id - CSID_BIAS;
      if (id >= CSID_THREE_BYTE_MIN) begin
         // low then high byte of id-64, wraps for ids past the legal range
         push_header_byte({fmt, 6'd1});
         push_header_byte(biased[7:0]);
         push_header_byte(biased[15:8]);
      end else if (id >= CSID_TWO_BYTE_MIN) begin
         push_header_byte({fmt, 6'd0});
         push_header_byte(biased[7:0]);
      end else begin
         // ids 0 and 1 land here too and come out as they are
         push_header_byte({fmt, id[5:0]});
      end
   endfunction

   function automatic logic [23:0] chunk_room();
      return (cfg_chunk_size == 24'd0) ? 24'd1 : cfg_chunk_size;
   endfunction

   // works out every byte one accepted item must produce
   function automatic void segment_byte(msg_byte_type m);
      logic [23:0] ts24;
      beat_type    beat;
      if (m.som) begin
         // any message in flight is dropped without an end mark
         msg_left   = 24'd0;
         chunk_left = 24'd0;
         if (m.mlen == 24'd0) return;
         cur_csid = m.csid;
         push_basic_header(FMT_TYPE0, m.csid);
         ts24 = (m.ts < 32'(TS_SAT)) ? m.ts[23:0] : TS_SAT;
         push_header_byte(ts24[23:16]);
         push_header_byte(ts24[15:8]);
         push_header_byte(ts24[7:0]);
         push_header_byte(m.mlen[23:16]);
         push_header_byte(m.mlen[15:8]);
         push_header_byte(m.mlen[7:0]);
         push_header_byte(m.mtype);
         // stream id goes out little-endian
         push_header_byte(m.msid[7:0]);
         push_header_byte(m.msid[15:8]);
         push_header_byte(m.msid[23:16]);
         push_header_byte(m.msid[31:24]);
         if (m.ts >= 32'(TS_SAT)) begin
            push_header_byte(m.ts[31:24]);
            push_header_byte(m.ts[23:16]);
            push_header_byte(m.ts[15:8]);
            push_header_byte(m.ts[7:0]);
         end
         msg_left   = m.mlen;
         chunk_left = chunk_room();
      end else begin
         if (msg_left == 24'd0) return;
         if (chunk_left == 24'd0) begin
            // chunk full: type-3 header, never an extended timestamp
            push_basic_header(FMT_TYPE3, cur_csid);
            chunk_left = chunk_room();
         end
      end
      msg_left   = msg_left - 24'd1;
      chunk_left = chunk_left - 24'd1;
      beat.out_byte       = m.data;
      beat.is_header      = 1'b0;
      beat.end_of_message = (msg_left == 24'd0);
      beat.last_of_run    = 1'b1;
      chunk_bytes_due.push_back(beat);
   endfunction

   // ------------------------------------------------------------------
   // item builders and gaps
   // ------------------------------------------------------------------

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic msg_byte_type start_of(logic [16:0] csid, logic [31:0] ts,
                                             logic [31:0] msid, logic [7:0] mtype,
                                             logic [23:0] mlen, logic [7:0] data);
      msg_byte_type m;
      m.data  = data;
      m.som   = 1'b1;
      m.csid  = csid;
      m.ts    = ts;
      m.msid  = msid;
      m.mtype = mtype;
      m.mlen  = mlen;
      return m;
   endfunction

   // continuation byte: header fields carry noise the block must ignore
   function automatic msg_byte_type payload(logic [7:0] data);
      msg_byte_type m;
      m = start_of(17'($urandom_range(0, 131071)), $urandom, $urandom,
                   8'($urandom_range(0, 255)), 24'($urandom_range(0, 16777215)), data);
      m.som = 1'b0;
      return m;
   endfunction

   function automatic msg_byte_type random_start(logic [23:0] mlen);
      logic [16:0] csid;
      logic [31:0] ts;
      case ($urandom_range(0, 3))
         0: csid = 17'($urandom_range(2, 63));
         1: csid = 17'($urandom_range(64, 319));
         2: csid = 17'($urandom_range(320, 65599));
         default: csid = 17'($urandom_range(0, 131071));
      endcase
      case ($urandom_range(0, 2))
         0: ts = $urandom_range(0, 1000);
         // straddle the saturation point
         1: ts = $urandom_range(32'h00FF_FFF0, 32'h0100_000F);
         default: ts = $urandom;
      endcase
      return start_of(csid, ts, $urandom, 8'($urandom_range(0, 255)), mlen,
                      8'($urandom_range(0, 255)));
   endfunction

   // ------------------------------------------------------------------
   // req driver, csr writer, drain
   // ------------------------------------------------------------------

   // valid stays high across back-to-back items; this task lowers it only for a gap
   task automatic send_item(msg_byte_type m);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m.som;
      req_tdata  <= REQ_DATA_W'({m.mlen, m.mtype, m.msid, m.ts, m.csid, m.data});
      do @(posedge clock); while (!req_tready);
      segment_byte(m);
   endtask

   // stop sending, let every owed byte come out, then let the pipeline settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (chunk_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup cycle then access cycle; pready is tied high so the access edge writes
   task automatic set_chunk_size(logic [23:0] size);
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CHUNK_SIZE_ADDR;
      csr_pwdata  <= CSR_DATA_W'(size);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      cfg_chunk_size = size;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // one-byte messages across every basic header form and timestamp corner
   task automatic test_header_forms();
      send_item(start_of(17'd0, 32'd0, 32'd0, 8'h00, 24'd1, 8'h00));
      send_item(start_of(17'd1, 32'h00FF_FFFE, 32'hFFFF_FFFF, 8'hFF, 24'd1, 8'hFF));
      send_item(start_of(17'd63, 32'h00FF_FFFF, 32'h1234_5678, 8'h14, 24'd1, 8'h5A));
      send_item(start_of(17'd64, 32'hFFFF_FFFF, 32'h8000_0001, 8'h09, 24'd1, 8'hA5));
      send_item(start_of(17'd319, 32'h0100_0000, 32'd1, 8'h08, 24'd1, 8'h01));
      send_item(start_of(17'd320, 32'h0001_0203, 32'hDEAD_BEEF, 8'h12, 24'd1, 8'h80));
      send_item(start_of(17'd65599, 32'h7FFF_FFFF, 32'd0, 8'h80, 24'd1, 8'h7F));
      // past the legal range, the biased id wraps in the two trailing bytes
      send_item(start_of(17'd131071, 32'h00FF_FFFF, 32'hFFFF_FFFF, 8'hFF, 24'd1, 8'hFE));
   endtask

   // stray bytes, empty messages and restarts in the middle of a message
   task automatic test_message_edges();
      // nothing active after the header tests: dropped
      send_item(payload(8'hC3));
      send_item(start_of(17'd5, 32'd100, 32'd7, 8'h09, 24'd3, 8'h11));
      send_item(payload(8'h22));
      // empty message cuts the active one short and produces nothing
      send_item(start_of(17'd6, 32'd200, 32'd8, 8'h08, 24'd0, 8'h33));
      send_item(payload(8'h44));
      // longest length, abandoned after a few bytes by a fresh start
      send_item(start_of(17'd400, 32'h1234_5678, 32'h0BAD_F00D, 8'h12, 24'hFF_FFFF, 8'h55));
      send_item(payload(8'h66));
      send_item(payload(8'h77));
      send_item(start_of(17'd70, 32'd0, 32'd0, 8'h14, 24'd2, 8'h88));
      send_item(payload(8'h99));
   endtask

   // chunk size of one, zero, and a change while a message is under way
   task automatic test_chunk_boundaries();
      set_chunk_size(24'd1);
      send_item(start_of(17'd70, 32'd10, 32'd1, 8'h09, 24'd3, 8'h01));
      send_item(payload(8'h02));
      send_item(payload(8'h03));
      // zero behaves as one
      set_chunk_size(24'd0);
      send_item(start_of(17'd400, 32'd20, 32'd2, 8'h08, 24'd2, 8'h04));
      send_item(payload(8'h05));
      set_chunk_size(24'd3);
      send_item(start_of(17'd9, 32'd30, 32'd3, 8'h12, 24'd5, 8'h06));
      send_item(payload(8'h07));
      // the chunk in progress keeps its last slot, then size one takes over
      set_chunk_size(24'd1);
      send_item(payload(8'h08));
      send_item(payload(8'h09));
      send_item(payload(8'h0A));
   endtask

   // random message traffic at a range of chunk sizes
   task automatic test_chunk_size_sweep();
      logic [23:0]  sizes [6];
      msg_byte_type m;
      int           sent;
      int           cut;
      int           r;
      sizes    = '{24'd1, 24'd2, 24'd7, CHUNK_SIZE_RESET, 24'hFF_FFFF, 24'd3};
      sizes[5] = 24'($urandom_range(3, 40));
      foreach (sizes[i]) begin
         set_chunk_size(sizes[i]);
         sent = 0;
         while (sent < ITEM_TARGET / 6) begin
            // every so often run a stretch flat out
            quiet = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 8) begin
               // noise: byte with no message, or continuing an abandoned one
               send_item(payload(8'($urandom_range(0, 255))));
            end else if (r < 12) begin
               send_item(random_start(24'd0));
            end else if (r < 14) begin
               drain_results();
            end else begin
               if (r < 22) begin
                  // huge length, cut off by whatever comes next
                  m   = random_start(24'($urandom_range(41, 16777215)));
                  cut = $urandom_range(1, 6);
               end else begin
                  m   = random_start(24'($urandom_range(1, 40)));
                  cut = (r < 30) ? $urandom_range(1, int'(m.mlen)) : int'(m.mlen);
               end
               send_item(m);
               for (int k = 1; k < cut; k++) send_item(payload(8'($urandom_range(0, 255))));
               sent += cut;
            end
         end
      end
      quiet = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // rsp side: random backpressure, checking, watchdog
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         rsp_hold   <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (chunk_bytes_due.size() == 0) begin
            $error("unexpected rsp item: out_byte %02h", rsp_tdata);
            errors++;
         end else begin
            want = chunk_bytes_due.pop_front();
            if (rsp_tdata !== want.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_tdata);
               errors++;
            end
            if (rsp_tuser[0] !== want.is_header) begin
               $error("is_header: expected %0b, got %0b", want.is_header, rsp_tuser[0]);
               errors++;
            end
            if (rsp_tuser[1] !== want.end_of_message) begin
               $error("end_of_message: expected %0b, got %0b",
                      want.end_of_message, rsp_tuser[1]);
               errors++;
            end
            if (rsp_tlast !== want.last_of_run) begin
               $error("last_of_run: expected %0b, got %0b", want.last_of_run, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb_rtmp_chunk_segmenter: errors");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      errors         = 0;
      quiet          = 1'b0;
      cfg_chunk_size = CHUNK_SIZE_RESET;
      cur_csid       = '0;
      msg_left       = '0;
      chunk_left     = '0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      rsp_tready  <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_header_forms();
      test_message_edges();
      test_chunk_boundaries();
      test_chunk_size_sweep();

      // the watchdog covers a block that never delivers what is owed
      drain_results();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("tb_rtmp_chunk_segmenter: clean");
      end else begin
         $display("tb_rtmp_chunk_segmenter: errors");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/rcs_pkg.sv
src/rcs_csr.sv
src/rcs_framer.sv
src/rcs_out_stage.sv
src/rtmp_chunk_segmenter.sv
src/rcs_checker.sv
tb/sv/tb_rtmp_chunk_segmenter.sv
